### hdl/ams_pkg.sv
// shared types and constants for the accumulator machine step unit
`default_nettype none
package ams_pkg;

    localparam int WORD_W = 32;
    localparam int PC_W   = 16;
    localparam int FUNC_W = 5;
    localparam int ST_W   = 3;
    localparam int CNT_W  = $clog2(WORD_W);

    typedef enum logic [FUNC_W-1:0] {
        OP_ADD = 5'd0,
        OP_SUB = 5'd1,
        OP_MUL = 5'd2,
        OP_DIV = 5'd3,
        OP_LDA = 5'd4,
        OP_LDK = 5'd5,
        OP_STA = 5'd6,
        OP_INP = 5'd7,
        OP_OUT = 5'd8,
        OP_HLT = 5'd9,
        OP_JMP = 5'd10,
        OP_JEZ = 5'd11,
        OP_JNE = 5'd12,
        OP_JLZ = 5'd13,
        OP_JLE = 5'd14,
        OP_JGZ = 5'd15,
        OP_JGE = 5'd16
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_RUN   = 3'd0,
        ST_HALT  = 3'd1,
        ST_END   = 3'd2,
        ST_BADOP = 3'd3,
        ST_DIVZ  = 3'd4
    } t_status;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic [PC_W-1:0]          operand;
        logic signed [WORD_W-1:0] input_value;
    } t_in_item;

    typedef struct packed {
        logic [PC_W-1:0]          next_pc;
        logic signed [WORD_W-1:0] acc_value;
        logic                     out_valid;
        logic signed [WORD_W-1:0] out_value;
        logic [ST_W-1:0]          status;
    } t_out_item;

endpackage
`default_nettype wire

### hdl/accumulator_machine_step_unit.sv
// accumulator machine step unit: executes one instruction per input transfer
// Each input transfer carries the instruction at the current program counter; one result
// transfer follows with the new pc, accumulator, OUT value and stop status. The storage
// registers sit in a synchronous memory with a registered read. An instruction passes
// from input transfer to result through register index, memory read and execute steps;
// DIV then also runs a one-bit-per-cycle restoring divider. A result that cannot leave
// because the output is stalled holds the unit until it is taken. A new input transfer
// is taken once the previous instruction has handed over its result. The user must write
// program_length through the configuration channel while the unit is idle; not enforced.
`default_nettype none
module accumulator_machine_step_unit #(
    parameter int REGISTER_COUNT = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire ams_pkg::t_in_item     i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output ams_pkg::t_out_item         o_out_data,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [15:0]           i_cfg_data
);
    import ams_pkg::*;

    localparam int IDX_W = $clog2(REGISTER_COUNT);
    localparam longint unsigned RECIP_L =
        ((64'd1 << 32) + 64'(REGISTER_COUNT) - 64'd1) / 64'(REGISTER_COUNT);
    localparam logic [31:0]     RECIP = 32'(RECIP_L);
    localparam logic [PC_W-1:0] RC    = PC_W'(REGISTER_COUNT);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_EXEC = 5'b00100,
        S_DIV  = 5'b01000,
        S_PUSH = 5'b10000
    } t_state;

    t_state                r_state, n_state;
    t_in_item              r_in;
    logic [PC_W-1:0]       r_idxq;
    logic [IDX_W-1:0]      r_idx;
    logic [47:0]           idx_prod;
    logic [PC_W-1:0]       idx_rem;
    logic [IDX_W-1:0]      rd_idx;

    logic [WORD_W-1:0]     mem [REGISTER_COUNT];
    logic [REGISTER_COUNT-1:0] r_valid;
    logic [WORD_W-1:0]     r_rdata;
    logic                  r_rvld;
    logic [WORD_W-1:0]     rv;

    logic [WORD_W-1:0]     r_acc;
    logic [PC_W-1:0]       r_pc;
    t_status               r_stop;
    logic [PC_W-1:0]       r_plen;

    logic [WORD_W-1:0]     x_acc;
    logic [PC_W-1:0]       x_pc;
    t_status               x_stop;
    logic                  x_we;
    logic [WORD_W-1:0]     x_wd;
    logic                  x_ov;
    logic [WORD_W-1:0]     x_oval;
    logic                  x_jump;
    logic                  x_div;
    logic [PC_W-1:0]       npc;

    logic [WORD_W-1:0]     r_drem;
    logic [WORD_W-1:0]     r_dq;
    logic [WORD_W-1:0]     r_ddvs;
    logic                  r_dneg;
    logic [CNT_W-1:0]      r_dcnt;
    logic [WORD_W-1:0]     d_sh;
    logic                  d_ge;
    logic [WORD_W-1:0]     d_rem;
    logic [WORD_W-1:0]     d_q;
    logic [WORD_W-1:0]     d_res;
    logic                  d_last;
    t_status               d_stop;

    logic                  commit;
    logic [WORD_W-1:0]     c_acc;
    logic [PC_W-1:0]       c_pc;
    t_status               c_stop;
    logic                  res_rdy;
    t_out_item             res;
    t_out_item             r_res;
    logic                  r_ovld;
    t_out_item             r_odata;
    logic                  out_free;
    logic                  in_xfer;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_ovld;
    assign o_out_data  = r_odata;
    assign out_free    = !r_ovld || !i_out_stall;

    // register index as operand modulo the register count, by reciprocal
    assign idx_prod = 48'(i_in_data.operand) * 48'(RECIP);
    assign idx_rem  = r_in.operand - PC_W'(r_idxq * RC);
    assign rd_idx   = idx_rem[IDX_W-1:0];
    assign rv       = r_rvld ? r_rdata : '0;
    assign npc      = r_pc + PC_W'(1);

    always_comb begin
        x_acc  = r_acc;
        x_pc   = r_pc;
        x_stop = r_stop;
        x_we   = 1'b0;
        x_wd   = r_acc;
        x_ov   = 1'b0;
        x_oval = '0;
        x_jump = 1'b0;
        x_div  = 1'b0;
        if (x_stop == ST_RUN && r_pc >= r_plen) begin
            x_stop = ST_END;
        end
        if (x_stop == ST_RUN) begin
            unique case (t_op'(r_in.func))
                OP_ADD: x_acc = r_acc + rv;
                OP_SUB: x_acc = r_acc - rv;
                OP_MUL: x_acc = WORD_W'(r_acc * rv);
                OP_DIV: begin
                    if (rv == '0) begin
                        x_stop = ST_DIVZ;
                    end else begin
                        x_div = 1'b1;
                    end
                end
                OP_LDA: x_acc = rv;
                OP_LDK: x_acc = WORD_W'(r_in.operand);
                OP_STA: begin
                    x_we = 1'b1;
                    x_wd = r_acc;
                end
                OP_INP: begin
                    x_we = 1'b1;
                    x_wd = r_in.input_value;
                end
                OP_OUT: begin
                    x_ov   = 1'b1;
                    x_oval = rv;
                end
                OP_HLT: x_stop = ST_HALT;
                OP_JMP: x_jump = 1'b1;
                OP_JEZ: x_jump = (r_acc == '0);
                OP_JNE: x_jump = (r_acc != '0);
                OP_JLZ: x_jump = r_acc[WORD_W-1];
                OP_JLE: x_jump = r_acc[WORD_W-1] || (r_acc == '0);
                OP_JGZ: x_jump = !r_acc[WORD_W-1] && (r_acc != '0);
                OP_JGE: x_jump = !r_acc[WORD_W-1];
                default: x_stop = ST_BADOP;
            endcase
            if (!x_div && (x_stop == ST_RUN || x_stop == ST_HALT)) begin
                x_pc = x_jump ? r_in.operand : npc;
                if (x_stop == ST_RUN && x_pc >= r_plen) begin
                    x_stop = ST_END;
                end
            end
        end
    end

    // restoring divider step on magnitudes
    assign d_sh   = {r_drem[WORD_W-2:0], r_dq[WORD_W-1]};
    assign d_ge   = (d_sh >= r_ddvs);
    assign d_rem  = d_ge ? (d_sh - r_ddvs) : d_sh;
    assign d_q    = {r_dq[WORD_W-2:0], d_ge};
    assign d_res  = r_dneg ? (WORD_W'(0) - d_q) : d_q;
    assign d_last = (r_dcnt == '0);
    assign d_stop = (npc >= r_plen) ? ST_END : ST_RUN;

    always_comb begin
        commit  = 1'b0;
        res_rdy = 1'b0;
        c_acc   = x_acc;
        c_pc    = x_pc;
        c_stop  = x_stop;
        res     = r_res;
        unique case (r_state)
            S_EXEC: begin
                commit  = !x_div;
                res_rdy = !x_div;
                res     = '{next_pc: x_pc, acc_value: x_acc, out_valid: x_ov,
                            out_value: x_oval, status: x_stop};
            end
            S_DIV: begin
                c_acc   = d_res;
                c_pc    = npc;
                c_stop  = d_stop;
                commit  = d_last;
                res_rdy = d_last;
                res     = '{next_pc: npc, acc_value: d_res, out_valid: 1'b0,
                            out_value: '0, status: d_stop};
            end
            S_PUSH: res_rdy = 1'b1;
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_xfer) n_state = S_READ;
            S_READ: n_state = S_EXEC;
            S_EXEC: begin
                if (x_div) begin
                    n_state = S_DIV;
                end else begin
                    n_state = out_free ? S_IDLE : S_PUSH;
                end
            end
            S_DIV: if (d_last) n_state = out_free ? S_IDLE : S_PUSH;
            S_PUSH: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovld  <= 1'b0;
            r_acc   <= '0;
            r_pc    <= '0;
            r_stop  <= ST_RUN;
            r_plen  <= 16'hFFFF;
            r_valid <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_plen <= i_cfg_data;
            end
            if (commit) begin
                r_acc  <= c_acc;
                r_pc   <= c_pc;
                r_stop <= c_stop;
            end
            if (r_state == S_EXEC && x_we) begin
                r_valid[r_idx] <= 1'b1;
            end
            if (res_rdy && out_free) begin
                r_ovld <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in   <= i_in_data;
            r_idxq <= idx_prod[47:32];
        end
        if (r_state == S_READ) begin
            r_idx  <= rd_idx;
            r_rvld <= r_valid[rd_idx];
        end
        if (res_rdy) begin
            if (out_free) begin
                r_odata <= res;
            end else begin
                r_res <= res;
            end
        end
        if (r_state == S_EXEC && x_div) begin
            r_drem <= '0;
            r_dq   <= r_acc[WORD_W-1] ? (WORD_W'(0) - r_acc) : r_acc;
            r_ddvs <= rv[WORD_W-1] ? (WORD_W'(0) - rv) : rv;
            r_dneg <= r_acc[WORD_W-1] ^ rv[WORD_W-1];
            r_dcnt <= CNT_W'(WORD_W - 1);
        end else if (r_state == S_DIV) begin
            r_drem <= d_rem;
            r_dq   <= d_q;
            r_dcnt <= r_dcnt - CNT_W'(1);
        end
    end

    // register file memory
    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_rdata <= mem[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC && x_we) begin
            mem[r_idx] <= x_wd;
        end
    end

endmodule
`default_nettype wire
